// ===== hw/rtl/kmp_pkg.sv =====
package kmp_pkg;

    localparam int PAT_MAX = 64;
    localparam int PAT_AW  = $clog2(PAT_MAX);
    localparam int LEN_W   = PAT_AW + 1;
    localparam int POS_W   = 16;

    localparam logic [LEN_W-1:0] LEN_FULL  = LEN_W'(PAT_MAX);
    localparam logic [POS_W-1:0] POS_LIMIT = '1;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_START  = 2'd2,
        CMD_TEXT   = 2'd3
    } t_cmd;

    typedef struct packed {
        logic latch;
        logic clear_pat;
        logic restart;
        logic set_ovf;
        logic write_first;
        logic load_build;
        logic load_text;
        logic mem_read;
        logic follow;
        logic commit_build;
        logic commit_text;
        logic bump_pos;
        logic set_done;
        logic load_result;
    } t_dp_ctrl;

    typedef struct packed {
        t_cmd cmd;
        logic byte_zero;
        logic last;
        logic done;
        logic len_zero;
        logic len_full;
        logic eq;
        logic q_zero;
        logic hit;
        logic out_free;
    } t_dp_stat;

    function automatic logic [7:0] fold(input logic [7:0] b, input logic cf);
        if (cf && b >= 8'h41 && b <= 8'h5A) begin
            return b + 8'd32;
        end
        return b;
    endfunction

endpackage

// ===== hw/rtl/kmp_datapath.sv =====
module kmp_datapath
    import kmp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_ctrl         i_ctrl,
    output t_dp_stat         o_stat,
    input  logic [1:0]       i_command,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last_byte,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_case_fold,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_found,
    output logic [POS_W-1:0] o_match_position,
    output logic             o_pattern_overflow
);

    logic [7:0]        pat_mem [PAT_MAX];
    logic [PAT_AW-1:0] pt_mem  [PAT_MAX];

    t_cmd              r_cmd;
    logic [7:0]        r_byte;
    logic              r_last;
    logic              r_cf;
    logic [LEN_W-1:0]  r_len;
    logic [PAT_AW-1:0] r_build;
    logic [LEN_W-1:0]  r_matched;
    logic [POS_W-1:0]  r_pos;
    logic              r_done;
    logic              r_ovf;
    logic [PAT_AW-1:0] r_q;
    logic [7:0]        r_pat_rd;
    logic [PAT_AW-1:0] r_pt_rd;
    logic              r_out_valid;
    logic              r_found;
    logic [POS_W-1:0]  r_mpos;
    logic              r_out_ovf;

    logic              eq;
    logic [LEN_W-1:0]  qn;
    logic [POS_W:0]    endp;
    logic [POS_W:0]    mcnt;
    logic              found_now;
    logic [POS_W-1:0]  pos_now;

    assign eq        = fold(r_pat_rd, r_cf) == fold(r_byte, r_cf);
    assign qn        = {1'b0, r_q} + (eq ? LEN_W'(1) : LEN_W'(0));
    assign endp      = {1'b0, r_pos} + (POS_W+1)'(1);
    assign mcnt      = (POS_W+1)'(r_matched);
    assign found_now = (r_len != '0) && (r_matched == r_len);
    assign pos_now   = (found_now && endp >= mcnt) ? POS_W'(endp - mcnt) : '0;

    always_comb begin
        o_stat.cmd       = r_cmd;
        o_stat.byte_zero = r_byte == 8'h00;
        o_stat.last      = r_last;
        o_stat.done      = r_done;
        o_stat.len_zero  = r_len == '0;
        o_stat.len_full  = r_len == LEN_FULL;
        o_stat.eq        = eq;
        o_stat.q_zero    = r_q == '0;
        o_stat.hit       = qn == r_len;
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    // pattern and prefix memories
    always_ff @(posedge i_clk) begin
        if (i_ctrl.write_first) begin
            pat_mem[r_len[PAT_AW-1:0]] <= r_byte;
            pt_mem[r_len[PAT_AW-1:0]]  <= '0;
        end else if (i_ctrl.commit_build) begin
            pat_mem[r_len[PAT_AW-1:0]] <= r_byte;
            pt_mem[r_len[PAT_AW-1:0]]  <= qn[PAT_AW-1:0];
        end
        if (i_ctrl.mem_read) begin
            r_pat_rd <= pat_mem[r_q];
            r_pt_rd  <= pt_mem[r_q - PAT_AW'(1)];
        end
    end

    // input beat and work registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.latch) begin
            r_cmd  <= t_cmd'(i_command);
            r_byte <= i_data_byte;
            r_last <= i_last_byte;
        end
        if (i_ctrl.load_build) begin
            r_q <= r_build;
        end else if (i_ctrl.load_text) begin
            r_q <= r_matched[PAT_AW-1:0];
        end else if (i_ctrl.follow) begin
            r_q <= r_pt_rd;
        end
        if (i_ctrl.load_result) begin
            r_found  <= found_now;
            r_mpos   <= pos_now;
            r_out_ovf <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cf        <= 1'b0;
            r_len       <= '0;
            r_build     <= '0;
            r_matched   <= '0;
            r_pos       <= '0;
            r_done      <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cf <= i_cfg_case_fold;
            end
            if (i_ctrl.clear_pat) begin
                r_len   <= '0;
                r_build <= '0;
                r_ovf   <= 1'b0;
            end
            if (i_ctrl.set_ovf) begin
                r_ovf <= 1'b1;
            end
            if (i_ctrl.write_first) begin
                r_build <= '0;
                r_len   <= r_len + LEN_W'(1);
            end
            if (i_ctrl.commit_build) begin
                r_build <= qn[PAT_AW-1:0];
                r_len   <= r_len + LEN_W'(1);
            end
            if (i_ctrl.restart) begin
                r_matched <= '0;
                r_pos     <= '0;
                r_done    <= 1'b0;
            end
            if (i_ctrl.commit_text) begin
                r_matched <= qn;
            end
            if (i_ctrl.bump_pos && r_pos < POS_LIMIT) begin
                r_pos <= r_pos + POS_W'(1);
            end
            if (i_ctrl.set_done) begin
                r_done <= 1'b1;
            end
            if (i_ctrl.load_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_found            = r_found;
    assign o_match_position   = r_mpos;
    assign o_pattern_overflow = r_out_ovf;

endmodule

// ===== hw/rtl/kmp_ctrl.sv =====
module kmp_ctrl
    import kmp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_ctrl o_ctrl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_READ,
        S_COMPARE,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_text;
    logic   n_text;

    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        o_ctrl  = '0;
        n_state = r_state;
        n_text  = r_text;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctrl.latch = 1'b1;
                    n_state      = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = S_IDLE;
                unique case (i_stat.cmd)
                    CMD_CLEAR: begin
                        o_ctrl.clear_pat = 1'b1;
                        o_ctrl.restart   = 1'b1;
                    end
                    CMD_APPEND: begin
                        if (i_stat.len_full) begin
                            o_ctrl.set_ovf = 1'b1;
                        end else if (i_stat.len_zero) begin
                            o_ctrl.write_first = 1'b1;
                        end else begin
                            o_ctrl.load_build = 1'b1;
                            n_text            = 1'b0;
                            n_state           = S_READ;
                        end
                    end
                    CMD_START: begin
                        o_ctrl.restart = 1'b1;
                    end
                    CMD_TEXT: begin
                        if (i_stat.done) begin
                            n_state = S_IDLE;
                        end else if (i_stat.byte_zero
                                     || (i_stat.len_zero && i_stat.last)) begin
                            o_ctrl.set_done = 1'b1;
                            n_state         = S_EMIT;
                        end else if (i_stat.len_zero) begin
                            o_ctrl.bump_pos = 1'b1;
                        end else begin
                            o_ctrl.load_text = 1'b1;
                            n_text           = 1'b1;
                            n_state          = S_READ;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_READ: begin
                o_ctrl.mem_read = 1'b1;
                n_state         = S_COMPARE;
            end
            S_COMPARE: begin
                if (!i_stat.eq && !i_stat.q_zero) begin
                    // mismatch: take the failure link
                    o_ctrl.follow = 1'b1;
                    n_state       = S_READ;
                end else if (!r_text) begin
                    o_ctrl.commit_build = 1'b1;
                    n_state             = S_IDLE;
                end else begin
                    o_ctrl.commit_text = 1'b1;
                    if (i_stat.hit || i_stat.last) begin
                        o_ctrl.set_done = 1'b1;
                        n_state         = S_EMIT;
                    end else begin
                        o_ctrl.bump_pos = 1'b1;
                        n_state         = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_ctrl.load_result = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_text  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_text  <= n_text;
        end
    end

endmodule

// ===== hw/rtl/kmp_pattern_matcher.sv =====
// Streaming KMP substring search. Commands on the input channel clear the
// pattern, append a pattern byte (up to 64, later bytes are dropped and
// flagged), start a new text, or feed a text byte. Each pattern byte's
// failure-link entry is built when it arrives. A text byte that finds the
// pattern, is zero, or carries last_byte gives one result beat; after that
// text bytes are ignored until the next start or clear. Control commands,
// the first or a dropped pattern byte, an ignored or zero text byte and a
// text byte against an empty pattern are handled in the dispatch state with
// no memory read; other pattern and text bytes go on to a read and a compare
// state, and back through both for each failure link followed (one read of
// the pattern and prefix memories and one compare per link). A result waits
// in the emit state while the previous result is still in the output
// register; the register then holds it while the next beat is taken.
// case_fold may be written on the config channel only while the block is idle.
module kmp_pattern_matcher
    import kmp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_case_fold,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_command,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last_byte,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_found,
    output logic [POS_W-1:0] o_match_position,
    output logic             o_pattern_overflow
);

    t_dp_ctrl ctrl;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    kmp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    kmp_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctrl             (ctrl),
        .o_stat             (stat),
        .i_command          (i_command),
        .i_data_byte        (i_data_byte),
        .i_last_byte        (i_last_byte),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_case_fold    (i_cfg_case_fold),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_found            (o_found),
        .o_match_position   (o_match_position),
        .o_pattern_overflow (o_pattern_overflow)
    );

endmodule
